/* design/hiv_pkg.sv */
// ----------------------------------------------------------------------------
// hiv_pkg: shared types and constants of the hostname/IPv4 validator
// Character classes, queue word layout and the octet acceptance function.
// ----------------------------------------------------------------------------
`default_nettype none

package hiv_pkg;

    // Character classes produced by the front end.
    typedef enum logic [2:0] {
        CLS_OTHER  = 3'd0,
        CLS_DIGIT  = 3'd1,
        CLS_DOT    = 3'd2,
        CLS_HYPHEN = 3'd3,
        CLS_ALPHA  = 3'd4
    } cls_t;

    // One classified word as it travels through the queue.
    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic       last;
    } entry_t;

    // Push side of the queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    localparam int unsigned QDEPTH = 2;

    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_Z   = 8'h7A;

    localparam logic [9:0] OCTET_MAX         = 10'd255;
    localparam logic [9:0] FIRST_OCTET_LIMIT = 10'd224;
    localparam logic [5:0] LABEL_MAX         = 6'd63;
    localparam logic [1:0] LAST_OCTET        = 2'd3;
    localparam logic [1:0] OCTET_DIGIT_LIMIT = 2'd3;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) r = CLS_DIGIT;
        else if (c == CHAR_DOT) r = CLS_DOT;
        else if (c == CHAR_HYPHEN) r = CLS_HYPHEN;
        else if ((c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z))
            r = CLS_ALPHA;
        else r = CLS_OTHER;
        return r;
    endfunction

    // True when the octet collected so far is acceptable.
    function automatic logic octet_ok(input logic [9:0] value, input logic [1:0] count,
                                      input logic zero_first, input logic [1:0] index);
        logic ok;
        ok = 1'b1;
        if (count == 2'd0 || value > OCTET_MAX) ok = 1'b0;
        if (zero_first && count > 2'd1) ok = 1'b0;
        if (index == 2'd0 && (value == 10'd0 || value >= FIRST_OCTET_LIMIT)) ok = 1'b0;
        return ok;
    endfunction

endpackage

`default_nettype wire

/* design/hiv_char_if.sv */
// ----------------------------------------------------------------------------
// hiv_char_if: byte channel into the validator
// Carries one byte of a name and the flag that marks its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface hiv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

/* design/hiv_verdict_if.sv */
// ----------------------------------------------------------------------------
// hiv_verdict_if: verdict channel out of the validator
// Carries one verdict word per name.
// ----------------------------------------------------------------------------
`default_nettype none

interface hiv_verdict_if;
    logic valid;
    logic ready;
    logic valid_res;
    logic numeric_form;
    logic too_long;

    modport source (output valid, output valid_res, output numeric_form,
                    output too_long, input ready);
    modport sink   (input valid, input valid_res, input numeric_form,
                    input too_long, output ready);
endinterface

`default_nettype wire

/* design/hiv_front.sv */
// ----------------------------------------------------------------------------
// hiv_front: byte classifier
// Accepts bytes and pushes their character class into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hiv_front (
    hiv_char_if.sink       chars,
    output hiv_pkg::push_t push,
    input  logic           push_ready
);
    import hiv_pkg::*;

    assign chars.ready       = push_ready;
    assign push.valid        = chars.valid;
    assign push.entry.cls    = classify(chars.char_code);
    assign push.entry.digit  = chars.char_code[3:0];
    assign push.entry.last   = chars.last_char;

endmodule

`default_nettype wire

/* design/hiv_queue.sv */
// ----------------------------------------------------------------------------
// hiv_queue: two-word queue between classifier and checker
// Lets the classifier keep accepting while the checker waits on its output.
// ----------------------------------------------------------------------------
`default_nettype none

module hiv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  hiv_pkg::push_t      push,
    output logic                push_ready,
    output logic                pop_valid,
    output hiv_pkg::entry_t     pop_entry,
    input  logic                pop
);
    import hiv_pkg::*;

    localparam int unsigned PtrW = $clog2(QDEPTH);
    localparam int unsigned CntW = $clog2(QDEPTH + 1);

    entry_t            mem_reg [QDEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg < CntW'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + CntW'(1);
        else if (!do_push && do_pop) count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= (wr_ptr_reg == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            if (do_pop)  rd_ptr_reg <= (rd_ptr_reg == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push.entry;
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QDEPTH))
        else $error("queue count above depth");

    // A lone push grows the fill count by one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("queue count did not grow on push");

    // A lone pop shrinks the fill count by one.
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - CntW'(1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

/* design/hiv_back.sv */
// ----------------------------------------------------------------------------
// hiv_back: dotted-quad and hostname checker
// Runs both checks on each classified word and registers one verdict per name.
// ----------------------------------------------------------------------------
`default_nettype none

module hiv_back #(
    parameter int unsigned MAX_LENGTH = 253
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  hiv_pkg::entry_t  pop_entry,
    output logic             pop,
    hiv_verdict_if.source    verdict
);
    import hiv_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_LENGTH);

    logic       odd_reg, odd_next;            // only digits and dots so far
    logic [1:0] oct_idx_reg, oct_idx_next;
    logic [9:0] oct_val_reg, oct_val_next;
    logic [1:0] oct_cnt_reg, oct_cnt_next;
    logic       oct_lz_reg, oct_lz_next;
    logic       ip_fail_reg, ip_fail_next;
    logic [5:0] label_len_reg, label_len_next;
    logic       prev_hyph_reg, prev_hyph_next;
    logic       host_fail_reg, host_fail_next;
    logic [7:0] byte_cnt_reg, byte_cnt_next;
    logic       overlong_reg, overlong_next;

    logic       out_valid_reg;
    logic       valid_res_reg, numeric_form_reg, too_long_reg;

    logic       is_digit, is_dot, is_hyphen, is_alpha;
    logic       ipv4_ok, host_ok, verdict_ok, finish;

    assign is_digit  = pop_entry.cls == CLS_DIGIT;
    assign is_dot    = pop_entry.cls == CLS_DOT;
    assign is_hyphen = pop_entry.cls == CLS_HYPHEN;
    assign is_alpha  = pop_entry.cls == CLS_ALPHA;

    // Take a word unless it closes a name and the verdict slot is still held.
    assign pop    = pop_valid && (!pop_entry.last || !out_valid_reg || verdict.ready);
    assign finish = pop && pop_entry.last;

    always_comb
    begin
        odd_next       = odd_reg && (is_digit || is_dot);
        oct_idx_next   = oct_idx_reg;
        oct_val_next   = oct_val_reg;
        oct_cnt_next   = oct_cnt_reg;
        oct_lz_next    = oct_lz_reg;
        ip_fail_next   = ip_fail_reg;
        label_len_next = label_len_reg;
        host_fail_next = host_fail_reg;
        prev_hyph_next = is_hyphen;
        byte_cnt_next  = byte_cnt_reg;
        overlong_next  = overlong_reg;

        if (byte_cnt_reg >= MaxLen) overlong_next = 1'b1;
        else byte_cnt_next = byte_cnt_reg + 8'd1;

        // Dotted-quad check. The octet value stays at most 99 before a digit
        // is added, so ten bits hold the product.
        if (!ip_fail_reg)
        begin
            if (is_digit)
            begin
                if (oct_cnt_reg >= OCTET_DIGIT_LIMIT) ip_fail_next = 1'b1;
                else
                begin
                    if (oct_cnt_reg == 2'd0) oct_lz_next = pop_entry.digit == 4'd0;
                    oct_val_next = {oct_val_reg[6:0], 3'b000} + {oct_val_reg[8:0], 1'b0}
                                 + {6'd0, pop_entry.digit};
                    oct_cnt_next = oct_cnt_reg + 2'd1;
                end
            end
            else if (is_dot)
            begin
                if (!octet_ok(oct_val_reg, oct_cnt_reg, oct_lz_reg, oct_idx_reg)
                    || oct_idx_reg >= LAST_OCTET)
                    ip_fail_next = 1'b1;
                else
                begin
                    oct_idx_next = oct_idx_reg + 2'd1;
                    oct_val_next = '0;
                    oct_cnt_next = '0;
                    oct_lz_next  = 1'b0;
                end
            end
            else ip_fail_next = 1'b1;
        end

        // Hostname check.
        if (!host_fail_reg)
        begin
            if (is_dot)
            begin
                if (label_len_reg == 6'd0 || prev_hyph_reg) host_fail_next = 1'b1;
                else label_len_next = '0;
            end
            else if ((!is_alpha && !is_digit && !is_hyphen)
                     || (label_len_reg == 6'd0 && is_hyphen)
                     || label_len_reg >= LABEL_MAX)
                host_fail_next = 1'b1;
            else label_len_next = label_len_reg + 6'd1;
        end

        ipv4_ok    = !ip_fail_next && octet_ok(oct_val_next, oct_cnt_next, oct_lz_next,
                                               oct_idx_next)
                     && oct_idx_next == LAST_OCTET;
        host_ok    = !host_fail_next && (is_dot || (label_len_next != 6'd0 && !is_hyphen));
        verdict_ok = odd_next ? ipv4_ok : host_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_reg       <= 1'b1;
            oct_idx_reg   <= '0;
            oct_val_reg   <= '0;
            oct_cnt_reg   <= '0;
            oct_lz_reg    <= 1'b0;
            ip_fail_reg   <= 1'b0;
            label_len_reg <= '0;
            prev_hyph_reg <= 1'b0;
            host_fail_reg <= 1'b0;
            byte_cnt_reg  <= '0;
            overlong_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                odd_reg       <= 1'b1;
                oct_idx_reg   <= '0;
                oct_val_reg   <= '0;
                oct_cnt_reg   <= '0;
                oct_lz_reg    <= 1'b0;
                ip_fail_reg   <= 1'b0;
                label_len_reg <= '0;
                prev_hyph_reg <= 1'b0;
                host_fail_reg <= 1'b0;
                byte_cnt_reg  <= '0;
                overlong_reg  <= 1'b0;
            end
            else if (pop)
            begin
                odd_reg       <= odd_next;
                oct_idx_reg   <= oct_idx_next;
                oct_val_reg   <= oct_val_next;
                oct_cnt_reg   <= oct_cnt_next;
                oct_lz_reg    <= oct_lz_next;
                ip_fail_reg   <= ip_fail_next;
                label_len_reg <= label_len_next;
                prev_hyph_reg <= prev_hyph_next;
                host_fail_reg <= host_fail_next;
                byte_cnt_reg  <= byte_cnt_next;
                overlong_reg  <= overlong_next;
            end

            if (finish) out_valid_reg <= 1'b1;
            else if (verdict.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            valid_res_reg    <= verdict_ok && !overlong_next;
            numeric_form_reg <= odd_next;
            too_long_reg     <= overlong_next;
        end
    end

    assign verdict.valid        = out_valid_reg;
    assign verdict.valid_res    = valid_res_reg;
    assign verdict.numeric_form = numeric_form_reg;
    assign verdict.too_long     = too_long_reg;

    // An overlong name is never reported as valid.
    a_long_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && too_long_reg) |-> !valid_res_reg)
        else $error("overlong name reported valid");

    // Closing a name leaves the checker state cleared for the next one.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (byte_cnt_reg == 8'd0 && odd_reg && !ip_fail_reg && !host_fail_reg))
        else $error("state not cleared after final word");

    // Closing a name always raises a verdict in the next cycle.
    a_verdict_raised: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("verdict missing after final word");

endmodule

`default_nettype wire

/* design/hostname_ipv4_validator_top.sv */
// ----------------------------------------------------------------------------
// hostname_ipv4_validator_top: server name validator
// Checks a name byte by byte as a hostname or a unicast dotted-quad address.
// ----------------------------------------------------------------------------
// The block takes one byte word per clock cycle on the chars channel while
// chars.ready is high, with last_char set on the final byte of a name, and
// returns one verdict word per name on the verdict channel. A name of only
// digits and dots is judged as a dotted-quad address (four octets, no leading
// zero, first octet 1 to 223); any other name is judged as a hostname (labels
// of letters, digits and hyphens, 1 to 63 long, no hyphen at either end,
// optional root dot). Names longer than MAX_LENGTH bytes are reported too_long
// and invalid. A classifier sorts each byte into a character class and pushes
// it into a two-word queue; the checker pops one word per cycle and updates a
// handful of small registers, so the sustained rate is one byte per cycle
// unless a verdict is held. The final byte is written into the queue and
// popped by the checker, which registers the verdict in an output register
// that drives verdict.valid and holds the word until taken. While a verdict
// waits, the checker still consumes the bytes of the next name and stalls
// only on that name's final byte, and the queue then holds that final byte
// and one byte after it before chars.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module hostname_ipv4_validator_top #(
    parameter int unsigned MAX_LENGTH = 253
) (
    input  logic           clk,
    input  logic           rst_n,
    hiv_char_if.sink       chars,
    hiv_verdict_if.source  verdict
);
    import hiv_pkg::*;

    push_t   push;
    logic    push_ready;
    logic    pop_valid;
    entry_t  pop_entry;
    logic    pop;

    hiv_front u_front (
        .chars      (chars),
        .push       (push),
        .push_ready (push_ready)
    );

    hiv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    hiv_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .verdict    (verdict)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the hostname/IPv4 validator
// Sends server names one byte word at a time, first from a directed table and
// then from a randomized mix of dotted quads, hostnames, damaged names, noise
// and long names. Every verdict word is checked field by field against a
// cycle-free model of the name checks. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import hiv_pkg::*;

    // The block's name length limit, also used by the local model.
    localparam int unsigned NAME_LIMIT = 253;

    // Number of random bytes to send after the directed table.
    localparam int RANDOM_BYTES = 900;

    // Cycles to wait once nothing is pending, and the limit for the drain.
    localparam int TAIL_CYCLES  = 8;
    localparam int DRAIN_LIMIT  = 5000;

    // Hard stop for a hung run, in time units.
    localparam int RUN_TIMEOUT  = 5000000;

    // A row with no extra final byte.
    localparam int NO_TAIL = -1;

    // One verdict word as the model predicts it.
    typedef struct packed {
        logic ok;
        logic numeric;
        logic overlong;
    } name_verdict_t;

    // Verdicts that can be read off a name directly.
    localparam name_verdict_t HOST_OK  = '{1'b1, 1'b0, 1'b0};
    localparam name_verdict_t HOST_BAD = '{1'b0, 1'b0, 1'b0};
    localparam name_verdict_t IP_OK    = '{1'b1, 1'b1, 1'b0};
    localparam name_verdict_t IP_BAD   = '{1'b0, 1'b1, 1'b0};
    localparam name_verdict_t LONG_TXT = '{1'b0, 1'b0, 1'b1};
    localparam name_verdict_t LONG_NUM = '{1'b0, 1'b1, 1'b1};

    // A directed row: text repeated reps times, then an optional final byte.
    // Rows with typed cleared are checked against the model instead.
    typedef struct {
        string         text;
        int            reps;
        int            tail;
        bit            typed;
        name_verdict_t want;
    } name_row_t;

    logic clk = 1'b0;
    logic rst_n;

    hiv_char_if    chars();
    hiv_verdict_if verdict();

    hostname_ipv4_validator_top #(
        .MAX_LENGTH (NAME_LIMIT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .verdict (verdict)
    );

    // Free-running clock, period 8.
    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Local model of the name checks. Its state mirrors the block's registers
    // (octet_index one bit wider) and returns to its reset value after each name.
    // ------------------------------------------------------------------------
    logic       only_digits_dots;
    logic [2:0] octet_index;
    logic [9:0] octet_value;
    logic [1:0] octet_digit_count;
    logic       octet_zero_first;
    logic       ipv4_failed;
    logic [5:0] label_length;
    logic       prev_was_hyphen;
    logic       hostname_failed;
    logic [7:0] byte_count;
    logic       overlong;

    // Verdicts predicted for accepted names and not yet seen on the output.
    name_verdict_t pending_verdicts[$];

    // Bytes of the name currently being built.
    logic [7:0] name_buf[$];

    // Run statistics and failure count.
    int mismatch_count   = 0;
    int bytes_sent       = 0;
    int names_sent       = 0;
    int verdicts_checked = 0;
    int numeric_checked  = 0;
    int overlong_checked = 0;
    int valid_checked    = 0;
    int drain_pauses     = 0;

    // Idling controls for the two channels, and the stall burst counter.
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int stall_left   = 0;

    // Characters used to build hostname labels, and characters that sit
    // right next to the digit and letter ranges.
    string label_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string edge_chars  = "/:@[`{";

    function automatic cls_t char_class(input logic [7:0] c);
        cls_t cls;
        if (c >= "0" && c <= "9") cls = CLS_DIGIT;
        else if (c == ".") cls = CLS_DOT;
        else if (c == "-") cls = CLS_HYPHEN;
        else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) cls = CLS_ALPHA;
        else cls = CLS_OTHER;
        return cls;
    endfunction

    // True when the octet gathered so far may close a dotted-quad field.
    function automatic logic octet_fits();
        logic fits;
        fits = 1'b1;
        if (octet_digit_count == 2'd0 || octet_value > 10'd255) fits = 1'b0;
        if (octet_zero_first && octet_digit_count > 2'd1) fits = 1'b0;
        if (octet_index == 3'd0 && (octet_value == 10'd0 || octet_value >= 10'd224))
            fits = 1'b0;
        return fits;
    endfunction

    task automatic clear_name_state();
        only_digits_dots   = 1'b1;
        octet_index        = 3'd0;
        octet_value        = 10'd0;
        octet_digit_count  = 2'd0;
        octet_zero_first   = 1'b0;
        ipv4_failed        = 1'b0;
        label_length       = 6'd0;
        prev_was_hyphen    = 1'b0;
        hostname_failed    = 1'b0;
        byte_count         = 8'd0;
        overlong           = 1'b0;
    endtask

    // Advances the model by one byte; on the final byte it yields the verdict.
    task automatic scan_name_byte(input logic [7:0] c, input logic last,
                                  output logic has_verdict, output name_verdict_t v);
        cls_t cls;
        logic ip_ok;
        logic host_ok;
        cls         = char_class(c);
        has_verdict = 1'b0;
        v           = '0;

        if (byte_count >= 8'(NAME_LIMIT)) overlong = 1'b1;
        else byte_count = byte_count + 8'd1;

        if (cls != CLS_DIGIT && cls != CLS_DOT) only_digits_dots = 1'b0;

        if (!ipv4_failed) begin
            if (cls == CLS_DIGIT) begin
                if (octet_digit_count >= 2'd3) begin
                    ipv4_failed = 1'b1;
                end else begin
                    if (octet_digit_count == 2'd0) octet_zero_first = (c == "0");
                    octet_value       = octet_value * 10'd10 + 10'(c - 8'h30);
                    octet_digit_count = octet_digit_count + 2'd1;
                end
            end else if (cls == CLS_DOT) begin
                if (!octet_fits() || octet_index >= 3'd3) begin
                    ipv4_failed = 1'b1;
                end else begin
                    octet_index        = octet_index + 3'd1;
                    octet_value        = 10'd0;
                    octet_digit_count  = 2'd0;
                    octet_zero_first   = 1'b0;
                end
            end else begin
                ipv4_failed = 1'b1;
            end
        end

        if (!hostname_failed) begin
            if (cls == CLS_DOT) begin
                if (label_length == 6'd0 || prev_was_hyphen) hostname_failed = 1'b1;
                else label_length = 6'd0;
            end else if (cls == CLS_OTHER || (label_length == 6'd0 && cls == CLS_HYPHEN) ||
                         label_length >= 6'd63) begin
                hostname_failed = 1'b1;
            end else begin
                label_length = label_length + 6'd1;
            end
        end
        prev_was_hyphen = (cls == CLS_HYPHEN);

        if (last) begin
            ip_ok       = !ipv4_failed && octet_fits() && octet_index == 3'd3;
            host_ok     = !hostname_failed &&
                          (cls == CLS_DOT || (label_length != 6'd0 && !prev_was_hyphen));
            v.ok        = (only_digits_dots ? ip_ok : host_ok) && !overlong;
            v.numeric   = only_digits_dots;
            v.overlong  = overlong;
            has_verdict = 1'b1;
            clear_name_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte channel driver. Inputs change on the falling edge; acceptance is
    // judged from ready as it stood just before the rising edge.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic last,
                             input bit typed, input name_verdict_t want);
        logic          has_verdict;
        name_verdict_t predicted;
        // An idle burst drops valid here and raises it on a later falling
        // edge, so valid never falls and rises within one time step.
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= c;
        chars.last_char <= last;
        @(posedge clk);
        while (!chars.ready) @(posedge clk);
        scan_name_byte(c, last, has_verdict, predicted);
        bytes_sent++;
        if (has_verdict) begin
            pending_verdicts.push_back(typed ? want : predicted);
            names_sent++;
        end
        @(negedge clk);
    endtask

    // Sends the bytes in name_buf, marking the final one.
    task automatic send_name(input bit typed, input name_verdict_t want);
        for (int i = 0; i < name_buf.size(); i++)
            send_byte(name_buf[i], i == name_buf.size() - 1, typed, want);
    endtask

    // Holds the byte channel idle until every predicted verdict has arrived.
    task automatic wait_for_verdicts();
        chars.valid <= 1'b0;
        @(negedge clk);
        while (pending_verdicts.size() != 0) @(negedge clk);
        drain_pauses++;
    endtask

    // ------------------------------------------------------------------------
    // Name builders for the random part.
    // ------------------------------------------------------------------------
    task automatic push_decimal(input int value);
        string s;
        s = $sformatf("%0d", value);
        for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    endtask

    // Mostly four octets in range; some out of range, padded with a leading
    // zero, or with an octet on the unicast boundary.
    task automatic build_ipv4();
        int octets;
        int value;
        octets = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
        for (int k = 0; k < octets; k++) begin
            if (k != 0) name_buf.push_back(".");
            case ($urandom_range(0, 9))
                0: value = $urandom_range(256, 9999);
                1: begin
                    name_buf.push_back("0");
                    value = $urandom_range(0, 99);
                end
                2: begin
                    case ($urandom_range(0, 3))
                        0: value = 0;
                        1: value = 223;
                        2: value = 224;
                        default: value = 255;
                    endcase
                end
                default: value = (k == 0) ? $urandom_range(1, 223) : $urandom_range(0, 255);
            endcase
            push_decimal(value);
        end
        if ($urandom_range(0, 14) == 0) name_buf.push_back(".");
    endtask

    // Labels of letters, digits and hyphens; a few labels near the 63 limit,
    // a few hyphens at a label edge, sometimes a root dot.
    task automatic build_hostname();
        int   labels;
        int   len;
        logic [7:0] ch;
        labels = $urandom_range(1, 4);
        for (int k = 0; k < labels; k++) begin
            if (k != 0) name_buf.push_back(".");
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 7) == 0) ch = "-";
                else ch = label_chars[$urandom_range(0, label_chars.len() - 1)];
                if (ch == "-" && (i == 0 || i == len - 1) && $urandom_range(0, 3) != 0)
                    ch = "x";
                name_buf.push_back(ch);
            end
        end
        if ($urandom_range(0, 5) == 0) name_buf.push_back(".");
    endtask

    // Damages one byte of a well-formed name, or slips in a boundary byte.
    task automatic corrupt_name();
        int pos;
        pos = $urandom_range(0, name_buf.size() - 1);
        case ($urandom_range(0, 3))
            0: name_buf[pos] = 8'($urandom_range(0, 255));
            1: name_buf[pos] = ".";
            2: name_buf[pos] = "-";
            default: name_buf.insert(pos, edge_chars[$urandom_range(0, edge_chars.len() - 1)]);
        endcase
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 16)) name_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Names around the length limit, either text labels or digit groups.
    task automatic build_long();
        int  target;
        bit  numeric;
        target  = $urandom_range(248, 258);
        numeric = $urandom_range(0, 2) == 0;
        for (int i = 0; i < target; i++) begin
            if (numeric) name_buf.push_back((i % 4 == 3) ? 8'h2E : 8'(8'h30 + $urandom_range(0, 9)));
            else name_buf.push_back((i % 41 == 40) ? 8'h2E : 8'(8'h61 + $urandom_range(0, 25)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Verdict channel: ready stalls in random bursts.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_left != 0) begin
            verdict.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
            verdict.ready <= 1'b0;
            stall_left = $urandom_range(0, 18);
        end else begin
            verdict.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH: %s", what);
    endtask

    // Each accepted verdict word is compared with the oldest prediction.
    always @(posedge clk) begin
        name_verdict_t want;
        if (rst_n === 1'b1 && verdict.valid === 1'b1 && verdict.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected verdict valid_res=%b numeric_form=%b too_long=%b",
                                          verdict.valid_res, verdict.numeric_form,
                                          verdict.too_long));
            end else begin
                want = pending_verdicts.pop_front();
                if (verdict.valid_res !== want.ok)
                    report_mismatch($sformatf("verdict %0d valid_res got %b want %b",
                                              verdicts_checked, verdict.valid_res, want.ok));
                if (verdict.numeric_form !== want.numeric)
                    report_mismatch($sformatf("verdict %0d numeric_form got %b want %b",
                                              verdicts_checked, verdict.numeric_form,
                                              want.numeric));
                if (verdict.too_long !== want.overlong)
                    report_mismatch($sformatf("verdict %0d too_long got %b want %b",
                                              verdicts_checked, verdict.too_long, want.overlong));
                numeric_checked  += want.numeric;
                overlong_checked += want.overlong;
                valid_checked    += want.ok;
            end
            verdicts_checked++;
        end
    end

    function automatic name_row_t make_row(input string text, input int reps, input int tail,
                                           input bit typed, input name_verdict_t want);
        name_row_t r;
        r.text  = text;
        r.reps  = reps;
        r.tail  = tail;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        name_row_t name_rows[$];
        int        random_bytes;
        int        pick;
        int        waited;
        bit        calm_tail;

        // Every input is known from time zero.
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = 8'h00;
        chars.last_char = 1'b0;
        verdict.ready   = 1'b0;
        clear_name_state();

        // The directed table. Rows typed with a verdict are the ones whose
        // answer is plain from the text; the rest go through the model.
        // Dotted quads at and beyond each octet rule:
        name_rows.push_back(make_row("1.2.3.4",         1,   NO_TAIL, 1, IP_OK));
        name_rows.push_back(make_row("223.255.255.255", 1,   NO_TAIL, 1, IP_OK));
        name_rows.push_back(make_row("224.0.0.1",       1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("0.1.2.3",         1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("0.0.0.0",         1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("10.01.2.3",       1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("10.0.256.3",      1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("1234.5.6.7",      1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("1.2.3",           1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("1.2.3.4.5",       1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("1.2.3.4.",        1,   NO_TAIL, 1, IP_BAD));
        // A lone dot, dots only, and a single digit.
        name_rows.push_back(make_row(".",               1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("...",             1,   NO_TAIL, 1, IP_BAD));
        name_rows.push_back(make_row("5",               1,   NO_TAIL, 1, IP_BAD));
        // Hostnames, including hyphen placement and a failure that sticks.
        name_rows.push_back(make_row("a",               1,   NO_TAIL, 1, HOST_OK));
        name_rows.push_back(make_row("Zz-9.example.com.", 1, NO_TAIL, 0, HOST_OK));
        name_rows.push_back(make_row("1a.2.3.4",        1,   NO_TAIL, 0, HOST_OK));
        name_rows.push_back(make_row("-abc",            1,   NO_TAIL, 1, HOST_BAD));
        name_rows.push_back(make_row("abc-",            1,   NO_TAIL, 1, HOST_BAD));
        name_rows.push_back(make_row("ab..cd",          1,   NO_TAIL, 1, HOST_BAD));
        name_rows.push_back(make_row("a@b",             1,   NO_TAIL, 1, HOST_BAD));
        // Label length at 63 and one past it.
        name_rows.push_back(make_row("a",               63,  NO_TAIL, 0, HOST_OK));
        name_rows.push_back(make_row("a",               64,  NO_TAIL, 1, HOST_BAD));
        // Zero byte and the top byte value.
        name_rows.push_back(make_row("ab",              1,   8'h00,   1, HOST_BAD));
        name_rows.push_back(make_row("",                1,   8'hFF,   1, HOST_BAD));
        // Exactly at the length limit, then one byte over, text and digits.
        name_rows.push_back(make_row("a.",              126, "b",     0, HOST_OK));
        name_rows.push_back(make_row("a.",              127, NO_TAIL, 1, LONG_TXT));
        name_rows.push_back(make_row("1",               254, NO_TAIL, 1, LONG_NUM));

        // Reset is held low, then released on a falling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with idling on both sides.
        foreach (name_rows[k]) begin
            name_buf.delete();
            repeat (name_rows[k].reps)
                for (int i = 0; i < name_rows[k].text.len(); i++)
                    name_buf.push_back(name_rows[k].text[i]);
            if (name_rows[k].tail != NO_TAIL) name_buf.push_back(8'(name_rows[k].tail));
            send_name(name_rows[k].typed, name_rows[k].want);
        end

        // Let every directed verdict drain before the random part begins.
        wait_for_verdicts();

        // Random part: mostly well-formed names with random content, the rest
        // damaged names, raw noise and names around the length limit. The
        // last stretch runs with no idling on either channel.
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            calm_tail    = random_bytes > RANDOM_BYTES * 85 / 100;
            src_idle_on  = !calm_tail && $urandom_range(0, 4) != 0;
            sink_idle_on = !calm_tail && $urandom_range(0, 4) != 0;
            name_buf.delete();
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                build_ipv4();
            end else if (pick < 78) begin
                build_hostname();
            end else if (pick < 90) begin
                if (pick < 84) build_ipv4();
                else build_hostname();
                corrupt_name();
            end else if (pick < 99) begin
                build_noise();
            end else begin
                build_long();
            end
            if (!calm_tail && $urandom_range(0, 39) == 0) wait_for_verdicts();
            send_name(1'b0, '0);
            random_bytes += name_buf.size();
        end

        // Drain what is still pending, then keep watching for any stray verdict
        // word.
        chars.valid  <= 1'b0;
        sink_idle_on  = 1'b0;
        waited        = 0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

        $display("Sent %0d names in %0d bytes; checked %0d verdicts (%0d valid, %0d numeric,",
                 names_sent, bytes_sent, verdicts_checked, valid_checked, numeric_checked);
        $display("%0d too long), with %0d full drain pauses and %0d mismatches.",
                 overlong_checked, drain_pauses, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(RUN_TIMEOUT);
        $display("Timeout with %0d verdicts pending.", pending_verdicts.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
